// ----- rtl/core/ipr_pkg.sv -----
// ipr_pkg: shared constants and helpers for the image plane rotator
// register indexes, direction codes, request actions, default sizes, dimension clamp
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

    localparam int DIM_BITS       = 7;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 7;
    localparam int DIR_BITS       = 2;
    localparam int PORT_PIX_BITS  = 64;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_PIXEL_BITS = 64;

    // value a dimension register takes at reset, before clamping
    localparam logic [DIM_BITS-1:0] RST_DIM = DIM_BITS'(64);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIR    = 2'd2;

    // rotation codes; the remaining code acts as the half turn
    localparam logic [DIR_BITS-1:0] DIR_CW   = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_CCW  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_HALF = 2'd2;

    // request actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // zero counts as one, anything above the store limit saturates
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input int unsigned lim);
        logic [DIM_BITS-1:0] d;
        d = (v == '0) ? DIM_BITS'(1) : v;
        if (32'(d) > lim) begin
            d = DIM_BITS'(lim);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ipr_store.sv -----
// ipr_store: single-port frame store, one access per cycle
// registered read data, no reset on contents
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module ipr_store #(
    parameter int DEPTH     = 4096,
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    output logic      [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/image_plane_rotator.sv -----
// image_plane_rotator: top level, load and read-out sequencing around the frame store
// depends on ipr_pkg and ipr_store
//
//   channel    ports                                   direction  handshake
//   request    start, busy, i_action, i_pixel_in       in         start && !busy
//   result     o_strobe, o_pixel_out, o_last_of_frame,
//              o_not_ready                             out        o_strobe, one cycle
//   config     i_cfg_we, i_cfg_index, i_cfg_data       in         i_cfg_we
//
// one request per cycle; a load takes one store write if no frame is loaded yet, and
// a read-out one store read if one is; a read-out result appears on the cycle after
// the request is accepted, set by the registered read port of the frame store
// synchronous reset clears counters and flags, resets sizes; the store is not cleared
// the receiver cannot stall, so busy stays low
`timescale 1ns / 1ps
`default_nettype none

module image_plane_rotator #(
    parameter int MAX_WIDTH  = ipr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ipr_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = ipr_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               i_action,
    input  wire logic [ipr_pkg::PORT_PIX_BITS-1:0]  i_pixel_in,
    output logic                                    o_strobe,
    output logic      [ipr_pkg::PORT_PIX_BITS-1:0]  o_pixel_out,
    output logic                                    o_last_of_frame,
    output logic                                    o_not_ready,
    input  wire logic                               i_cfg_we,
    input  wire logic [ipr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [ipr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DB    = ipr_pkg::DIM_BITS;

    // configuration
    logic [DB-1:0]                 r_width;
    logic [DB-1:0]                 r_height;
    logic [ipr_pkg::DIR_BITS-1:0]  r_dir;

    // frame sequencing
    logic [DB-1:0] r_ld_row, r_ld_col, n_ld_row, n_ld_col;
    logic [DB-1:0] r_out_row, r_out_col, n_out_row, n_out_col;
    logic          r_loaded, n_loaded;

    // read pipeline
    logic r_strobe, r_last, r_nrdy;

    logic            accept, do_load, do_read, quarter, last, cfg_hit;
    logic [DB-1:0]   dst_w, dst_h, src_row, src_col;
    logic [AW-1:0]   wr_addr, rd_addr, mem_addr;
    logic [PIXEL_BITS-1:0] mem_q;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign do_load = accept && (i_action == ipr_pkg::ACT_LOAD) && !r_loaded;
    assign do_read = accept && (i_action == ipr_pkg::ACT_READ) && r_loaded;
    assign cfg_hit = i_cfg_we && (i_cfg_index == ipr_pkg::CFG_WIDTH
                               || i_cfg_index == ipr_pkg::CFG_HEIGHT
                               || i_cfg_index == ipr_pkg::CFG_DIR);

    assign quarter = (r_dir == ipr_pkg::DIR_CW) || (r_dir == ipr_pkg::DIR_CCW);
    assign dst_w   = quarter ? r_height : r_width;
    assign dst_h   = quarter ? r_width  : r_height;
    assign last    = (r_out_row == dst_h - DB'(1)) && (r_out_col == dst_w - DB'(1));

    always_comb begin
        case (r_dir)
            ipr_pkg::DIR_CW: begin
                src_row = r_height - DB'(1) - r_out_col;
                src_col = r_out_row;
            end
            ipr_pkg::DIR_CCW: begin
                src_row = r_out_col;
                src_col = r_width - DB'(1) - r_out_row;
            end
            default: begin
                src_row = r_height - DB'(1) - r_out_row;
                src_col = r_width  - DB'(1) - r_out_col;
            end
        endcase
    end

    // row pitch is the maximum width
    assign wr_addr  = AW'(32'(r_ld_row) * MAX_WIDTH + 32'(r_ld_col));
    assign rd_addr  = AW'(32'(src_row)  * MAX_WIDTH + 32'(src_col));
    assign mem_addr = (i_action == ipr_pkg::ACT_READ) ? rd_addr : wr_addr;

    ipr_store #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (AW),
        .DATA_BITS (PIXEL_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_re    (do_read),
        .i_addr  (mem_addr),
        .i_wdata (i_pixel_in[PIXEL_BITS-1:0]),
        .o_rdata (mem_q)
    );

    always_comb begin
        n_ld_row  = r_ld_row;
        n_ld_col  = r_ld_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_loaded  = r_loaded;
        if (do_load) begin
            if (r_ld_col == r_width - DB'(1)) begin
                n_ld_col = '0;
                if (r_ld_row == r_height - DB'(1)) begin
                    n_ld_row = '0;
                    n_loaded = 1'b1;
                end else begin
                    n_ld_row = r_ld_row + DB'(1);
                end
            end else begin
                n_ld_col = r_ld_col + DB'(1);
            end
        end
        if (do_read) begin
            if (last) begin
                n_out_row = '0;
                n_out_col = '0;
                n_loaded  = 1'b0;
            end else if (r_out_col == dst_w - DB'(1)) begin
                n_out_col = '0;
                n_out_row = r_out_row + DB'(1);
            end else begin
                n_out_col = r_out_col + DB'(1);
            end
        end
        // a register write restarts the frame
        if (cfg_hit) begin
            n_ld_row  = '0;
            n_ld_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
            n_loaded  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= ipr_pkg::clamp_dim(ipr_pkg::RST_DIM, MAX_WIDTH);
            r_height  <= ipr_pkg::clamp_dim(ipr_pkg::RST_DIM, MAX_HEIGHT);
            r_dir     <= ipr_pkg::DIR_CW;
            r_ld_row  <= '0;
            r_ld_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_loaded  <= 1'b0;
            r_strobe  <= 1'b0;
            r_last    <= 1'b0;
            r_nrdy    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ipr_pkg::CFG_WIDTH:  r_width  <= ipr_pkg::clamp_dim(i_cfg_data, MAX_WIDTH);
                    ipr_pkg::CFG_HEIGHT: r_height <= ipr_pkg::clamp_dim(i_cfg_data, MAX_HEIGHT);
                    ipr_pkg::CFG_DIR:    r_dir    <= i_cfg_data[ipr_pkg::DIR_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            r_ld_row  <= n_ld_row;
            r_ld_col  <= n_ld_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_loaded  <= n_loaded;
            r_strobe  <= accept && (i_action == ipr_pkg::ACT_READ);
            r_last    <= do_read && last;
            r_nrdy    <= !r_loaded;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_last_of_frame = r_last;
    assign o_not_ready     = r_nrdy;
    assign o_pixel_out     = r_nrdy ? '0 : ipr_pkg::PORT_PIX_BITS'(mem_q);

    // every read-out request gets its result on the next cycle
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && i_action == ipr_pkg::ACT_READ) |=> o_strobe)
        else $error("read-out request without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_action == ipr_pkg::ACT_READ))
        else $error("result without request");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_last_of_frame && o_not_ready))
        else $error("end of frame flagged on a not-ready result");

    // a loaded frame leaves the load counters parked at the origin
    a_load_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded |-> (r_ld_row == '0 && r_ld_col == '0))
        else $error("load counters moved while frame loaded");

endmodule

`default_nettype wire
